[rtl/hsf_pkg.sv]
// ----------------------------------------------------------------------------
// hsf_pkg
// Shared types and constants for the 1bpp horizontal span fill block.
// ----------------------------------------------------------------------------
package hsf_pkg;

    localparam int SCREEN_BYTES = 1024;
    localparam int FB_AW        = $clog2(SCREEN_BYTES);

    localparam logic [7:0] ROW_WIDTH_RESET = 8'd16;

    localparam logic [1:0] MODE_DRAW   = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [9:0] x_start;
        logic [9:0] x_end;
        logic [9:0] row;
        logic [9:0] byte_address;
    } hsf_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       status;
    } hsf_out_t;

    // geometry of one span, as handed to the sequencer
    typedef struct packed {
        logic [FB_AW-1:0] first_addr;
        logic [FB_AW-1:0] last_addr;
        logic [FB_AW-1:0] fill_first;
        logic [FB_AW-1:0] fill_last;
        logic [7:0]       mask_lo;
        logic [7:0]       mask_hi;
        logic             single;
        logic             has_mid;
        logic             skip;
        logic             status;
    } hsf_span_t;

endpackage

[rtl/hsf_ram.sv]
// ----------------------------------------------------------------------------
// hsf_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module hsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/hsf_geom.sv]
// ----------------------------------------------------------------------------
// hsf_geom
// Two-stage span geometry: ordering, clipping, row base, masks, range check.
// ----------------------------------------------------------------------------
module hsf_geom (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [9:0]         x_start,
    input  logic [9:0]         x_end,
    input  logic [9:0]         row,
    input  logic [7:0]         row_width,
    output logic               span_valid,
    output hsf_pkg::hsf_span_t span
);
    import hsf_pkg::*;

    logic [9:0]  lo_next;
    logic [9:0]  hi_raw;
    logic [10:0] last_pixel;
    logic [9:0]  hi_next;
    logic        rej_next;
    logic        clip_next;
    logic [17:0] base_next;

    logic [9:0]  lo_reg;
    logic [9:0]  hi_reg;
    logic        rej_reg;
    logic        clip_reg;
    logic [17:0] base_reg;
    logic        v1_reg;

    logic [6:0]  first_byte;
    logic [6:0]  last_byte;
    logic [18:0] first_full;
    logic [18:0] last_full;
    logic        beyond;
    hsf_span_t   span_next;
    hsf_span_t   span_reg;
    logic        span_valid_reg;

    // stage 1
    always_comb
    begin
        lo_next    = (x_start <= x_end) ? x_start : x_end;
        hi_raw     = (x_start <= x_end) ? x_end : x_start;
        last_pixel = {row_width, 3'b000} - 11'd1;
        rej_next   = (row_width == 8'd0) || ({1'b0, lo_next} > last_pixel);
        clip_next  = ({1'b0, hi_raw} > last_pixel);
        hi_next    = clip_next ? last_pixel[9:0] : hi_raw;
        base_next  = {8'd0, row} * {10'd0, row_width};
    end

    // stage 2
    always_comb
    begin
        first_byte = lo_reg[9:3];
        last_byte  = hi_reg[9:3];
        first_full = {1'b0, base_reg} + {12'd0, first_byte};
        last_full  = {1'b0, base_reg} + {12'd0, last_byte};
        beyond     = (32'(last_full) >= SCREEN_BYTES);

        span_next.first_addr = FB_AW'(first_full);
        span_next.last_addr  = FB_AW'(last_full);
        span_next.fill_first = FB_AW'(first_full + 19'd1);
        span_next.fill_last  = FB_AW'(last_full - 19'd1);
        span_next.mask_lo    = 8'hFF >> lo_reg[2:0];
        span_next.mask_hi    = ~(8'hFF >> ({1'b0, hi_reg[2:0]} + 4'd1));
        span_next.single     = (first_byte == last_byte);
        span_next.has_mid    = ((last_byte - first_byte) > 7'd1);
        span_next.skip       = rej_reg || beyond;
        span_next.status     = rej_reg || beyond || clip_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            span_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg         <= in_valid;
            span_valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            lo_reg   <= lo_next;
            hi_reg   <= hi_next;
            rej_reg  <= rej_next;
            clip_reg <= clip_next;
            base_reg <= base_next;
        end
        if (v1_reg)
        begin
            span_reg <= span_next;
        end
    end

    assign span_valid = span_valid_reg;
    assign span       = span_reg;

endmodule

[rtl/horizontal_span_fill_1bpp.sv]
// ----------------------------------------------------------------------------
// horizontal_span_fill_1bpp
// 1bpp framebuffer with horizontal span draw, byte read and full clear.
// ----------------------------------------------------------------------------
// One item at a time: start is taken while busy is low, and each item gives
// exactly one result on result, flagged by a one-cycle done pulse that cannot
// be held off. Everything goes through one single-port framebuffer RAM, so
// time follows memory accesses: a draw passes through geometry and setup,
// then each partial end byte is read, then OR-written, and each whole middle
// byte is written once; a draw that is rejected ends after geometry. A read
// makes one RAM read; the unused mode needs no memory access. A clear writes
// every byte. After reset the block runs the same clearing pass with busy
// high and no result; row width writes are taken at any time.
module horizontal_span_fill_1bpp (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  hsf_pkg::hsf_in_t cmd,
    output logic             done,
    output hsf_pkg::hsf_out_t result,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_data
);
    import hsf_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_GEOM,
        S_RD_FIRST,
        S_WR_FIRST,
        S_RD_LAST,
        S_WR_LAST,
        S_FILL,
        S_RDWAIT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [FB_AW-1:0] cnt_reg;
    logic [FB_AW-1:0] cnt_next;
    logic             done_reg;
    logic             done_next;
    hsf_out_t         result_reg;
    hsf_out_t         result_next;
    logic             clr_report_reg;
    logic             clr_report_next;
    logic [7:0]       row_width_reg;

    logic             accept;
    logic             geom_start;
    logic             span_valid;
    hsf_span_t        span;

    logic             ram_we;
    logic [FB_AW-1:0] ram_addr;
    logic [7:0]       ram_wdata;
    logic [7:0]       ram_rdata;

    assign accept     = start && !busy;
    assign geom_start = accept && (cmd.mode == MODE_DRAW);

    hsf_geom u_geom (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (geom_start),
        .x_start    (cmd.x_start),
        .x_end      (cmd.x_end),
        .row        (cmd.row),
        .row_width  (row_width_reg),
        .span_valid (span_valid),
        .span       (span)
    );

    hsf_ram #(
        .WIDTH (8),
        .DEPTH (SCREEN_BYTES)
    ) u_fb (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg <= ROW_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            row_width_reg <= cfg_data;
        end
    end

    // memory port
    always_comb
    begin
        ram_we    = 1'b0;
        ram_addr  = FB_AW'(cmd.byte_address);
        ram_wdata = 8'h00;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = cnt_reg;
            end
            S_RD_FIRST:
            begin
                ram_addr = span.first_addr;
            end
            S_WR_FIRST:
            begin
                ram_we    = 1'b1;
                ram_addr  = span.first_addr;
                ram_wdata = ram_rdata | (span.single ? (span.mask_lo & span.mask_hi)
                                                     : span.mask_lo);
            end
            S_RD_LAST:
            begin
                ram_addr = span.last_addr;
            end
            S_WR_LAST:
            begin
                ram_we    = 1'b1;
                ram_addr  = span.last_addr;
                ram_wdata = ram_rdata | span.mask_hi;
            end
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_addr  = cnt_reg;
                ram_wdata = 8'hFF;
            end
            S_IDLE, S_GEOM, S_RDWAIT:
            begin
                ram_we = 1'b0;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        done_next       = 1'b0;
        result_next     = '0;
        clr_report_next = clr_report_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == FB_AW'(SCREEN_BYTES - 1))
                begin
                    state_next = S_IDLE;
                    done_next  = clr_report_reg;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.mode)
                        MODE_DRAW:
                        begin
                            state_next = S_GEOM;
                        end
                        MODE_READ:
                        begin
                            if (32'(cmd.byte_address) < SCREEN_BYTES)
                            begin
                                state_next = S_RDWAIT;
                            end
                            else
                            begin
                                done_next          = 1'b1;
                                result_next.status = 1'b1;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            state_next      = S_CLEAR;
                            cnt_next        = '0;
                            clr_report_next = 1'b1;
                        end
                        MODE_UNUSED:
                        begin
                            done_next          = 1'b1;
                            result_next.status = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_GEOM:
            begin
                if (span_valid)
                begin
                    if (span.skip)
                    begin
                        state_next         = S_IDLE;
                        done_next          = 1'b1;
                        result_next.status = span.status;
                    end
                    else
                    begin
                        state_next = S_RD_FIRST;
                    end
                end
            end
            S_RD_FIRST:
            begin
                state_next = S_WR_FIRST;
            end
            S_WR_FIRST:
            begin
                if (span.single)
                begin
                    state_next         = S_IDLE;
                    done_next          = 1'b1;
                    result_next.status = span.status;
                end
                else
                begin
                    state_next = S_RD_LAST;
                end
            end
            S_RD_LAST:
            begin
                state_next = S_WR_LAST;
            end
            S_WR_LAST:
            begin
                if (span.has_mid)
                begin
                    state_next = S_FILL;
                    cnt_next   = span.fill_first;
                end
                else
                begin
                    state_next         = S_IDLE;
                    done_next          = 1'b1;
                    result_next.status = span.status;
                end
            end
            S_FILL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == span.fill_last)
                begin
                    state_next         = S_IDLE;
                    done_next          = 1'b1;
                    result_next.status = span.status;
                end
            end
            S_RDWAIT:
            begin
                state_next            = S_IDLE;
                done_next             = 1'b1;
                result_next.read_data = ram_rdata;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cnt_reg        <= '0;
            done_reg       <= 1'b0;
            result_reg     <= '0;
            clr_report_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            done_reg       <= done_next;
            result_reg     <= result_next;
            clr_report_reg <= clr_report_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while an item is still in progress");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> busy)
        else $error("framebuffer written while idle");

    a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd.mode == MODE_UNUSED) |=> (done && result.status))
        else $error("unused mode item not rejected in the next cycle");

    a_fill_inside: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == S_FILL) |->
            (ram_addr > span.first_addr && ram_addr < span.last_addr))
        else $error("middle byte fill outside the span");

    a_read_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(state_reg) != S_RDWAIT) |-> (result.read_data == 8'h00))
        else $error("non-zero read data on an item other than a read");

endmodule

[tb/sv/horizontal_span_fill_1bpp_tb.sv]
// ----------------------------------------------------------------------------
// horizontal_span_fill_1bpp_tb
// Self-checking bench for the 1bpp span fill block. A directed table covers
// reset contents, field extremes, every mode and each repair case (swapped,
// clipped, off-row and off-store spans). Random items then run under several
// row widths, including zero and the top of the register range. Every result
// is checked against a mirror framebuffer in the bench or a hand-typed value.
// ----------------------------------------------------------------------------
module horizontal_span_fill_1bpp_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hsf_pkg::*;

    localparam int RANDOM_ITEMS   = 450;
    localparam int PHASES         = 6;
    localparam int WATCHDOG_LIMIT = 4 * (SCREEN_BYTES + 128);

    typedef struct {
        hsf_in_t  cmd;
        logic     typed;
        hsf_out_t want;
    } table_row_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       start    = 1'b0;
    logic       busy;
    hsf_in_t    cmd      = '0;
    logic       done;
    hsf_out_t   result;
    logic       cfg_we   = 1'b0;
    logic [7:0] cfg_data = '0;

    // bench-side tag travelling with cmd: use a hand-typed result for this item
    logic       row_typed    = 1'b0;
    hsf_out_t   row_expected = '0;

    logic [7:0]  fb_mirror [SCREEN_BYTES] = '{default: 8'h00};
    int unsigned row_width_mirror = 32'(ROW_WIDTH_RESET);
    hsf_out_t    pending_results [$];

    int unsigned errors    = 0;
    int unsigned gap_pct   = 0;
    int unsigned recent_base = 0;
    int unsigned n_draw    = 0;
    int unsigned n_read    = 0;
    int unsigned n_clear   = 0;
    int unsigned n_unused  = 0;

    table_row_t directed_steps [24] = '{
        '{'{MODE_READ,   10'd0,    10'd0,    10'd0,    10'd0},    1'b1, '{8'h00, 1'b0}},
        '{'{MODE_READ,   10'd1023, 10'd1023, 10'd1023, 10'd1023}, 1'b1, '{8'h00, 1'b0}},
        '{'{MODE_UNUSED, 10'd1023, 10'd1023, 10'd1023, 10'd1023}, 1'b1, '{8'h00, 1'b1}},
        '{'{MODE_UNUSED, 10'd0,    10'd0,    10'd0,    10'd0},    1'b1, '{8'h00, 1'b1}},
        '{'{MODE_DRAW,   10'd0,    10'd0,    10'd0,    10'd0},    1'b0, '{8'h00, 1'b0}},
        '{'{MODE_DRAW,   10'd3,    10'd5,    10'd1,    10'd0},    1'b0, '{8'h00, 1'b0}},
        '{'{MODE_DRAW,   10'd100,  10'd10,   10'd2,    10'd0},    1'b0, '{8'h00, 1'b0}},
        '{'{MODE_DRAW,   10'd0,    10'd127,  10'd3,    10'd0},    1'b0, '{8'h00, 1'b0}},
        '{'{MODE_DRAW,   10'd5,    10'd1023, 10'd4,    10'd0},    1'b0, '{8'h00, 1'b0}},
        '{'{MODE_DRAW,   10'd200,  10'd300,  10'd5,    10'd0},    1'b1, '{8'h00, 1'b1}},
        '{'{MODE_DRAW,   10'd1023, 10'd128,  10'd6,    10'd0},    1'b1, '{8'h00, 1'b1}},
        '{'{MODE_DRAW,   10'd0,    10'd127,  10'd63,   10'd0},    1'b0, '{8'h00, 1'b0}},
        '{'{MODE_DRAW,   10'd0,    10'd0,    10'd64,   10'd0},    1'b1, '{8'h00, 1'b1}},
        '{'{MODE_DRAW,   10'd1023, 10'd0,    10'd1023, 10'd0},    1'b1, '{8'h00, 1'b1}},
        '{'{MODE_DRAW,   10'd7,    10'd8,    10'd10,   10'd0},    1'b0, '{8'h00, 1'b0}},
        '{'{MODE_DRAW,   10'd8,    10'd15,   10'd10,   10'd0},    1'b0, '{8'h00, 1'b0}},
        '{'{MODE_READ,   10'd0,    10'd0,    10'd0,    10'd0},    1'b0, '{8'h00, 1'b0}},
        '{'{MODE_READ,   10'd0,    10'd0,    10'd0,    10'd16},   1'b0, '{8'h00, 1'b0}},
        '{'{MODE_READ,   10'd0,    10'd0,    10'd0,    10'd47},   1'b0, '{8'h00, 1'b0}},
        '{'{MODE_READ,   10'd0,    10'd0,    10'd0,    10'd1023}, 1'b0, '{8'h00, 1'b0}},
        '{'{MODE_READ,   10'd0,    10'd0,    10'd0,    10'd160},  1'b0, '{8'h00, 1'b0}},
        '{'{MODE_CLEAR,  10'd1023, 10'd1023, 10'd1023, 10'd1023}, 1'b1, '{8'h00, 1'b0}},
        '{'{MODE_READ,   10'd0,    10'd0,    10'd0,    10'd1023}, 1'b1, '{8'h00, 1'b0}},
        '{'{MODE_READ,   10'd0,    10'd0,    10'd0,    10'd48},   1'b1, '{8'h00, 1'b0}}
    };

    horizontal_span_fill_1bpp u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ORs the span into the mirror; returns the status bit
    function automatic logic fill_span(input int unsigned xa, input int unsigned xb,
                                       input int unsigned y);
        int unsigned w;
        int unsigned lo;
        int unsigned hi;
        int unsigned last_px;
        int unsigned base;
        int unsigned first_b;
        int unsigned last_b;
        logic [7:0]  m_lo;
        logic [7:0]  m_hi;
        logic        clipped;
        w       = row_width_mirror;
        clipped = 1'b0;
        if (w == 0)
            return 1'b1;
        lo      = (xa <= xb) ? xa : xb;
        hi      = (xa <= xb) ? xb : xa;
        last_px = w * 8 - 1;
        if (lo > last_px)
            return 1'b1;
        if (hi > last_px)
        begin
            hi      = last_px;
            clipped = 1'b1;
        end
        base    = y * w;
        first_b = lo / 8;
        last_b  = hi / 8;
        if (base + last_b >= SCREEN_BYTES)
            return 1'b1;
        m_lo = 8'hFF >> (lo % 8);
        m_hi = ~(8'hFF >> (hi % 8 + 1));
        if (first_b == last_b)
            fb_mirror[FB_AW'(base + first_b)] |= m_lo & m_hi;
        else
        begin
            fb_mirror[FB_AW'(base + first_b)] |= m_lo;
            fb_mirror[FB_AW'(base + last_b)]  |= m_hi;
            for (int unsigned a = first_b + 1; a < last_b; a++)
                fb_mirror[FB_AW'(base + a)] = 8'hFF;
        end
        return clipped;
    endfunction

    function automatic hsf_out_t predict_response(input hsf_in_t c);
        hsf_out_t r;
        r = '0;
        case (c.mode)
            MODE_DRAW:
                r.status = fill_span(32'(c.x_start), 32'(c.x_end), 32'(c.row));
            MODE_READ:
                if (c.byte_address < SCREEN_BYTES)
                    r.read_data = fb_mirror[c.byte_address];
                else
                    r.status = 1'b1;
            MODE_CLEAR:
                foreach (fb_mirror[i])
                    fb_mirror[i] = 8'h00;
            default:
                r.status = 1'b1;
        endcase
        return r;
    endfunction

    // mostly well-placed spans and reads near recent drawing; the rest is noise
    function automatic hsf_in_t random_item(input int unsigned w);
        hsf_in_t     c;
        int unsigned pick;
        int unsigned last_px;
        int unsigned max_row;
        int unsigned xe;
        c.x_start      = 10'($urandom_range(1023));
        c.x_end        = 10'($urandom_range(1023));
        c.row          = 10'($urandom_range(1023));
        c.byte_address = 10'($urandom_range(1023));
        pick = $urandom_range(99);
        if (pick < 56)
            c.mode = MODE_DRAW;
        else if (pick < 92)
            c.mode = MODE_READ;
        else if (pick < 96)
            c.mode = MODE_CLEAR;
        else
            c.mode = MODE_UNUSED;
        if (w != 0)
        begin
            last_px = w * 8 - 1;
            if (last_px > 1023)
                last_px = 1023;
            max_row = (SCREEN_BYTES - 1) / w;
            if (max_row > 1023)
                max_row = 1023;
            if (c.mode == MODE_DRAW && $urandom_range(99) < 80)
            begin
                c.row     = 10'($urandom_range(max_row));
                c.x_start = 10'($urandom_range(last_px));
                if ($urandom_range(99) < 60)
                begin
                    xe = c.x_start + $urandom_range(40);
                    c.x_end = (xe > 1023) ? 10'd1023 : 10'(xe);
                end
                else
                    c.x_end = 10'($urandom_range(last_px));
                recent_base = c.row * w;
            end
            else if (c.mode == MODE_READ && $urandom_range(99) < 70)
            begin
                xe = recent_base + $urandom_range(w - 1);
                c.byte_address = (xe > 1023) ? 10'd1023 : 10'(xe);
            end
        end
        return c;
    endfunction

    task automatic issue(input hsf_in_t c, input logic typed, input hsf_out_t typed_val);
        int unsigned gap;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        cmd          <= c;
        row_typed    <= typed;
        row_expected <= typed_val;
        do
            @(posedge clk);
        while (busy);
        case (c.mode)
            MODE_DRAW:  n_draw++;
            MODE_READ:  n_read++;
            MODE_CLEAR: n_clear++;
            default:    n_unused++;
        endcase
    endtask

    // hold off until every outstanding result is back
    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
        @(posedge clk);
    endtask

    task automatic set_row_width(input logic [7:0] v);
        cfg_data <= v;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        hsf_out_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("[%0t] unexpected result: actual %02h/%0b", $time,
                             result.read_data, result.status);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (result.read_data !== want.read_data)
                    begin
                        $display("[%0t] read_data mismatch: expected %02h, actual %02h",
                                 $time, want.read_data, result.read_data);
                        errors++;
                    end
                    if (result.status !== want.status)
                    begin
                        $display("[%0t] status mismatch: expected %0b, actual %0b",
                                 $time, want.status, result.status);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                want = predict_response(cmd);
                if (row_typed)
                    want = row_expected;
                pending_results.push_back(want);
            end
            if (cfg_we)
                row_width_mirror = 32'(cfg_data);
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (done || (start && !busy))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] timeout: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("horizontal_span_fill_1bpp test failed");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0]  widths [PHASES];
        int unsigned idx;
        widths = '{8'd1, 8'd128, 8'd0, 8'd255, 8'd0, 8'd0};
        widths[4] = 8'($urandom_range(2, 127));
        widths[5] = 8'($urandom_range(0, 255));
        idx = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct = 17;
        foreach (directed_steps[i])
            issue(directed_steps[i].cmd, directed_steps[i].typed, directed_steps[i].want);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            set_row_width(widths[p]);
            for (int k = 0; k < RANDOM_ITEMS / PHASES; k++)
            begin
                gap_pct = (idx < RANDOM_ITEMS / 3) ? 17 : (idx < 2 * RANDOM_ITEMS / 3) ? 76 : 0;
                issue(random_item(32'(widths[p])), 1'b0, '0);
                idx++;
            end
            drain();
        end

        repeat (16) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("[%0t] %0d results never arrived", $time, pending_results.size());
            errors++;
        end
        $display("covered %0d draws, %0d reads, %0d clears, %0d unused-mode items",
                 n_draw, n_read, n_clear, n_unused);
        $display("row widths: 16 %0d %0d %0d %0d %0d %0d; %0d errors",
                 widths[0], widths[1], widths[2], widths[3], widths[4], widths[5], errors);
        if (errors == 0)
            $display("horizontal_span_fill_1bpp test passed");
        else
            $display("horizontal_span_fill_1bpp test failed");
        $finish;
    end

endmodule

[sim.f]
rtl/hsf_pkg.sv
rtl/hsf_ram.sv
rtl/hsf_geom.sv
rtl/horizontal_span_fill_1bpp.sv
tb/sv/horizontal_span_fill_1bpp_tb.sv
